[rtl/core/siasmd_pkg.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// siasmd_pkg - shared types and codes of the signed add/sub/mul/div unit
// Operation codes and the control and status bundles between the sequencer
// and the shift unit.
// ----------------------------------------------------------------------------
package siasmd_pkg;

   localparam int OP_WIDTH = 2;

   typedef logic [OP_WIDTH-1:0] op_type;

   localparam op_type OP_ADD = 2'd0;
   localparam op_type OP_SUB = 2'd1;
   localparam op_type OP_MUL = 2'd2;
   localparam op_type OP_DIV = 2'd3;

   // Command from the sequencer to the shift unit.
   typedef struct packed {
      logic start;
      logic is_div;
   } eng_ctl_type;

   // Status of the shift unit.
   typedef struct packed {
      logic busy;
      logic done;
   } eng_status_type;

endpackage

[rtl/core/siasmd_req_if.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// siasmd_req_if - request channel
// Valid/ready channel that carries one operation code and two operands.
// ----------------------------------------------------------------------------
interface siasmd_req_if import siasmd_pkg::*; #(
   parameter int DATA_WIDTH = 32
) ();
   logic                         valid;
   logic                         ready;
   op_type                       op;
   logic signed [DATA_WIDTH-1:0] operand_a;
   logic signed [DATA_WIDTH-1:0] operand_b;

   modport source (output valid, output op, output operand_a, output operand_b,
                   input ready);
   modport sink   (input valid, input op, input operand_a, input operand_b,
                   output ready);
endinterface

[rtl/core/siasmd_rsp_if.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// siasmd_rsp_if - result channel
// Valid/ready channel that carries the value, remainder and zero-divisor flag.
// ----------------------------------------------------------------------------
interface siasmd_rsp_if #(
   parameter int DATA_WIDTH = 32
) ();
   logic                         valid;
   logic                         ready;
   logic signed [DATA_WIDTH-1:0] value;
   logic signed [DATA_WIDTH-1:0] remainder_out;
   logic                         divide_by_zero;

   modport source (output valid, output value, output remainder_out,
                   output divide_by_zero, input ready);
   modport sink   (input valid, input value, input remainder_out,
                   input divide_by_zero, output ready);
endinterface

[rtl/core/siasmd_shift_unit.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// siasmd_shift_unit - bit-serial multiply / restoring divide
// One operand bit per cycle, MSB first. The shift
// register holds the multiplier or the dividend and collects quotient bits;
// the work register holds the partial product or the partial remainder.
// ----------------------------------------------------------------------------
module siasmd_shift_unit import siasmd_pkg::*; #(
   parameter int DATA_WIDTH = 32
) (
   input  logic                  clock,
   input  logic                  reset,
   input  eng_ctl_type           ctl,
   input  logic [DATA_WIDTH-1:0] mag_a,
   input  logic [DATA_WIDTH-1:0] mag_b,
   output eng_status_type        status,
   output logic [DATA_WIDTH-1:0] work,
   output logic [DATA_WIDTH-1:0] shift_word
);

   localparam int CNT_W = $clog2(DATA_WIDTH);
   localparam logic [CNT_W-1:0] LAST_STEP = CNT_W'(DATA_WIDTH - 1);

   logic                  busy_ff, busy_in;
   logic                  done_ff, done_in;
   logic                  div_ff, div_in;
   logic [CNT_W-1:0]      count_ff, count_in;
   logic [DATA_WIDTH-1:0] shift_ff, shift_in;
   logic [DATA_WIDTH-1:0] work_ff, work_in;
   logic [DATA_WIDTH-1:0] divisor_ff, divisor_in;

   logic                  top_bit;
   logic [DATA_WIDTH:0]   trial;
   logic [DATA_WIDTH+1:0] diff;
   logic                  fits;
   logic [DATA_WIDTH-1:0] mac;

   assign top_bit = shift_ff[DATA_WIDTH-1];
   assign trial   = {work_ff, top_bit};
   assign diff    = {1'b0, trial} - {2'b00, divisor_ff};
   assign fits    = ~diff[DATA_WIDTH+1];
   assign mac     = {work_ff[DATA_WIDTH-2:0], 1'b0} + (top_bit ? divisor_ff : '0);

   always_comb begin
      busy_in    = busy_ff;
      done_in    = 1'b0;
      div_in     = div_ff;
      count_in   = count_ff;
      shift_in   = shift_ff;
      work_in    = work_ff;
      divisor_in = divisor_ff;
      if (ctl.start) begin
         busy_in    = 1'b1;
         div_in     = ctl.is_div;
         count_in   = '0;
         shift_in   = mag_a;
         work_in    = '0;
         divisor_in = mag_b;
      end else if (busy_ff) begin
         if (div_ff) begin
            // restore on a failed trial subtract
            work_in  = fits ? diff[DATA_WIDTH-1:0] : trial[DATA_WIDTH-1:0];
            shift_in = {shift_ff[DATA_WIDTH-2:0], fits};
         end else begin
            work_in  = mac;
            shift_in = {shift_ff[DATA_WIDTH-2:0], 1'b0};
         end
         count_in = count_ff + CNT_W'(1);
         if (count_ff == LAST_STEP) begin
            busy_in = 1'b0;
            done_in = 1'b1;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         busy_ff  <= 1'b0;
         done_ff  <= 1'b0;
         count_ff <= '0;
      end else begin
         busy_ff  <= busy_in;
         done_ff  <= done_in;
         count_ff <= count_in;
      end
   end

   always_ff @(posedge clock) begin
      div_ff     <= div_in;
      shift_ff   <= shift_in;
      work_ff    <= work_in;
      divisor_ff <= divisor_in;
   end

   assign status.busy = busy_ff;
   assign status.done = done_ff;
   assign work        = work_ff;
   assign shift_word  = shift_ff;

`ifndef SYNTHESIS
   a_start_busy: assert property (@(posedge clock) disable iff (reset)
      ctl.start |=> busy_ff)
      else $error("shift unit did not start");
   a_last_done: assert property (@(posedge clock) disable iff (reset)
      (busy_ff && !ctl.start && count_ff == LAST_STEP) |=> (done_ff && !busy_ff))
      else $error("shift unit did not finish after the last step");
   a_done_idle: assert property (@(posedge clock) disable iff (reset)
      done_ff |-> !busy_ff)
      else $error("shift unit done while still busy");
`endif

endmodule

[rtl/core/signed_int_add_sub_mul_div.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// signed_int_add_sub_mul_div - signed add, subtract, multiply and divide
// Usage:
//   req_if (sink) takes one item: op (0 add, 1 sub, 2 mul, 3 div) and two
//   two's complement operands. An item is taken when valid and ready are high.
//   rsp_if (source) returns one item per request: value, remainder_out and
//   divide_by_zero. Add, sub and mul wrap; divide truncates toward zero and
//   the remainder keeps the dividend's sign.
//   A zero divisor sets divide_by_zero, returns 0 and the dividend as remainder.
// Flow:
//   Add, sub and zero-divisor items pass from acceptance through the prepare
//   and sign fix-up steps to the output register; multiply and divide also
//   run in the shift unit, which retires one operand bit per cycle. One item
//   is in flight at a time; ready is high only while the sequencer is idle,
//   so a new item is taken only after the last one has left the fix-up step.
// Reset and stall:
//   Synchronous reset drops any item in flight and clears the result valid.
//   The result sits in an output register, so a new item is accepted while
//   the receiver stalls; the next result waits in the sign fix-up step
//   until that register frees up.
// ----------------------------------------------------------------------------
module signed_int_add_sub_mul_div import siasmd_pkg::*; #(
   parameter int DATA_WIDTH = 32
) (
   input logic         clock,
   input logic         reset,
   siasmd_req_if.sink   req_if,
   siasmd_rsp_if.source rsp_if
);

   // sequencer states
   localparam logic [1:0] ST_IDLE = 2'd0;
   localparam logic [1:0] ST_PREP = 2'd1;
   localparam logic [1:0] ST_RUN  = 2'd2;
   localparam logic [1:0] ST_FIX  = 2'd3;

   logic [1:0]            state_ff, state_in;
   op_type                op_ff, op_in;
   logic [DATA_WIDTH-1:0] a_ff, a_in;
   logic [DATA_WIDTH-1:0] b_ff, b_in;

   // result staged before the sign fix
   logic [DATA_WIDTH-1:0] res_value_ff, res_value_in;
   logic [DATA_WIDTH-1:0] res_rem_ff, res_rem_in;
   logic                  res_dz_ff, res_dz_in;
   logic                  neg_q_ff, neg_q_in;
   logic                  neg_r_ff, neg_r_in;

   // output register
   logic                  out_valid_ff, out_valid_in;
   logic [DATA_WIDTH-1:0] out_value_ff, out_value_in;
   logic [DATA_WIDTH-1:0] out_rem_ff, out_rem_in;
   logic                  out_dz_ff, out_dz_in;

   logic                  a_neg, b_neg, b_zero;
   logic [DATA_WIDTH-1:0] mag_a, mag_b;

   eng_ctl_type           eng_ctl;
   eng_status_type        eng_status;
   logic [DATA_WIDTH-1:0] eng_work;
   logic [DATA_WIDTH-1:0] eng_shift;

   assign a_neg  = a_ff[DATA_WIDTH-1];
   assign b_neg  = b_ff[DATA_WIDTH-1];
   assign b_zero = (b_ff == '0);
   assign mag_a  = a_neg ? (~a_ff + 1'b1) : a_ff;
   assign mag_b  = b_neg ? (~b_ff + 1'b1) : b_ff;

   siasmd_shift_unit #(
      .DATA_WIDTH (DATA_WIDTH)
   ) u_shift_unit (
      .clock      (clock),
      .reset      (reset),
      .ctl        (eng_ctl),
      .mag_a      (mag_a),
      .mag_b      (mag_b),
      .status     (eng_status),
      .work       (eng_work),
      .shift_word (eng_shift)
   );

   always_comb begin
      state_in     = state_ff;
      op_in        = op_ff;
      a_in         = a_ff;
      b_in         = b_ff;
      res_value_in = res_value_ff;
      res_rem_in   = res_rem_ff;
      res_dz_in    = res_dz_ff;
      neg_q_in     = neg_q_ff;
      neg_r_in     = neg_r_ff;
      eng_ctl      = '0;
      // drop the held result once the receiver takes it
      out_valid_in = out_valid_ff & ~rsp_if.ready;
      out_value_in = out_value_ff;
      out_rem_in   = out_rem_ff;
      out_dz_in    = out_dz_ff;

      case (state_ff)
         ST_IDLE: begin
            if (req_if.valid) begin
               op_in    = req_if.op;
               a_in     = req_if.operand_a;
               b_in     = req_if.operand_b;
               state_in = ST_PREP;
            end
         end
         ST_PREP: begin
            res_rem_in = '0;
            res_dz_in  = 1'b0;
            neg_q_in   = 1'b0;
            neg_r_in   = 1'b0;
            state_in   = ST_FIX;
            case (op_ff)
               OP_ADD: res_value_in = a_ff + b_ff;
               OP_SUB: res_value_in = a_ff - b_ff;
               OP_MUL: begin
                  eng_ctl.start = 1'b1;
                  neg_q_in      = a_neg ^ b_neg;
                  state_in      = ST_RUN;
               end
               OP_DIV: begin
                  if (b_zero) begin
                     // zero divisor: flag it, pass the dividend through
                     res_value_in = '0;
                     res_rem_in   = a_ff;
                     res_dz_in    = 1'b1;
                  end else begin
                     eng_ctl.start  = 1'b1;
                     eng_ctl.is_div = 1'b1;
                     neg_q_in       = a_neg ^ b_neg;
                     neg_r_in       = a_neg;
                     state_in       = ST_RUN;
                  end
               end
               default: res_value_in = '0;
            endcase
         end
         ST_RUN: begin
            if (eng_status.done) begin
               if (op_ff == OP_DIV) begin
                  res_value_in = eng_shift;
                  res_rem_in   = eng_work;
               end else begin
                  res_value_in = eng_work;
                  res_rem_in   = '0;
               end
               state_in = ST_FIX;
            end
         end
         ST_FIX: begin
            // hold here while the output register is still full
            if (!out_valid_ff || rsp_if.ready) begin
               out_valid_in = 1'b1;
               out_value_in = neg_q_ff ? (~res_value_ff + 1'b1) : res_value_ff;
               out_rem_in   = neg_r_ff ? (~res_rem_ff + 1'b1) : res_rem_ff;
               out_dz_in    = res_dz_ff;
               state_in     = ST_IDLE;
            end
         end
         default: state_in = ST_IDLE;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_IDLE;
         out_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         out_valid_ff <= out_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      op_ff        <= op_in;
      a_ff         <= a_in;
      b_ff         <= b_in;
      res_value_ff <= res_value_in;
      res_rem_ff   <= res_rem_in;
      res_dz_ff    <= res_dz_in;
      neg_q_ff     <= neg_q_in;
      neg_r_ff     <= neg_r_in;
      out_value_ff <= out_value_in;
      out_rem_ff   <= out_rem_in;
      out_dz_ff    <= out_dz_in;
   end

   assign req_if.ready         = (state_ff == ST_IDLE);
   assign rsp_if.valid         = out_valid_ff;
   assign rsp_if.value         = out_value_ff;
   assign rsp_if.remainder_out = out_rem_ff;
   assign rsp_if.divide_by_zero = out_dz_ff;

`ifndef SYNTHESIS
   a_run_to_fix: assert property (@(posedge clock) disable iff (reset)
      (state_ff == ST_RUN && eng_status.done) |=> (state_ff == ST_FIX))
      else $error("sequencer missed the shift unit's done");
   a_dz_zero_value: assert property (@(posedge clock) disable iff (reset)
      (out_valid_ff && out_dz_ff) |-> (out_value_ff == '0))
      else $error("zero-divisor item with nonzero value");
   a_load_from_fix: assert property (@(posedge clock) disable iff (reset)
      $rose(out_valid_ff) |-> ($past(state_ff) == ST_FIX))
      else $error("result loaded outside the fix-up step");
`endif

endmodule
